// File: hdl/yuvp_pkg.sv
// ----------------------------------------------------------------------------
// yuvp_pkg
// Shared types and constants of the YUV to RGB pixel packer.
// ----------------------------------------------------------------------------
package yuvp_pkg;

  // Largest frame dimension the raster counters must cover
  localparam int MAX_DIMENSION_DEF = 4096;

  // Field widths of the streams and registers
  localparam int SAMPLE_W   = 8;
  localparam int WORD_W     = 32;
  localparam int BYTES_W    = 3;
  localparam int CFG_DIM_W  = 13;
  localparam int CFG_FMT_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd2;

  // Valid byte counts of a packed pixel
  localparam logic [BYTES_W-1:0] BYTES_WORD   = 3'd4;
  localparam logic [BYTES_W-1:0] BYTES_PACKED = 3'd3;

  // Output layouts
  typedef enum logic [CFG_FMT_W-1:0] {
    FMT_BGRA = 3'd0,
    FMT_ABGR = 3'd1,
    FMT_BGR  = 3'd2,
    FMT_RGBA = 3'd3,
    FMT_RGB  = 3'd4
  } fmt_t;

  // Raster position flags of one pixel
  typedef struct packed {
    logic row_end;
    logic frame_end;
  } pos_flags_t;

endpackage

// File: hdl/yuvp_raster.sv
// ----------------------------------------------------------------------------
// yuvp_raster
// Column and row counters that flag the last pixel of each row and frame.
// ----------------------------------------------------------------------------
module yuvp_raster #(
  parameter int MAX_DIMENSION = yuvp_pkg::MAX_DIMENSION_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [yuvp_pkg::CFG_DIM_W-1:0] frame_width,
  input  logic [yuvp_pkg::CFG_DIM_W-1:0] frame_height,
  output yuvp_pkg::pos_flags_t           flags
);

  localparam int CNT_W = $clog2(MAX_DIMENSION);
  localparam int CMP_W = (CNT_W + 1 > yuvp_pkg::CFG_DIM_W) ? CNT_W + 1 : yuvp_pkg::CFG_DIM_W;
  localparam logic [CMP_W-1:0] MAX_DIM = CMP_W'(MAX_DIMENSION);

  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CMP_W-1:0] w_ext, h_ext, w_last, h_last;

  // Clamp dimensions to 1..MAX and take the last index
  always_comb begin
    w_ext = CMP_W'(frame_width);
    h_ext = CMP_W'(frame_height);
    if (w_ext == '0) begin
      w_last = '0;
    end else if (w_ext > MAX_DIM) begin
      w_last = MAX_DIM - CMP_W'(1);
    end else begin
      w_last = w_ext - CMP_W'(1);
    end
    if (h_ext == '0) begin
      h_last = '0;
    end else if (h_ext > MAX_DIM) begin
      h_last = MAX_DIM - CMP_W'(1);
    end else begin
      h_last = h_ext - CMP_W'(1);
    end
  end

  // A counter at or past the last index ends the row or frame
  assign flags.row_end   = CMP_W'(col_r) >= w_last;
  assign flags.frame_end = flags.row_end && (CMP_W'(row_r) >= h_last);

  // Advance the counters on each request
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (step) begin
      if (flags.row_end) begin
        col_nxt = '0;
        row_nxt = flags.frame_end ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Frame end restarts both counters
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    step && flags.frame_end |=> col_r == '0 && row_r == '0)
    else $error("raster counters did not restart after frame end");

  // Mid-row step moves one column, same row
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    step && !flags.row_end |=> col_r == $past(col_r) + CNT_W'(1) && row_r == $past(row_r))
    else $error("column counter did not advance by one");

endmodule

// File: hdl/yuvp_convert.sv
// ----------------------------------------------------------------------------
// yuvp_convert
// BT.601 limited-range YUV to RGB conversion and layout packing.
// ----------------------------------------------------------------------------
module yuvp_convert (
  input  logic [yuvp_pkg::SAMPLE_W-1:0] luma,
  input  logic [yuvp_pkg::SAMPLE_W-1:0] chroma_blue,
  input  logic [yuvp_pkg::SAMPLE_W-1:0] chroma_red,
  input  yuvp_pkg::fmt_t                output_format,
  output logic [yuvp_pkg::WORD_W-1:0]   pixel_word,
  output logic [yuvp_pkg::BYTES_W-1:0]  byte_count
);

  localparam int ACC_W = 20;

  logic signed [ACC_W-1:0] y_s, u_s, v_s;
  logic signed [ACC_W-1:0] r_t, g_t, b_t;
  logic [7:0] r8, g8, b8;

  // Floor divide by 256 and saturate to 0..255
  function automatic logic [7:0] scale_sat(input logic signed [ACC_W-1:0] t);
    logic signed [ACC_W-9:0] q;
    q = ACC_W'(t >>> 8) >= 0 ? (ACC_W-8)'(t >>> 8) : (ACC_W-8)'(t >>> 8);
    if (q < 0) begin
      return 8'd0;
    end else if (q > 255) begin
      return 8'd255;
    end else begin
      return q[7:0];
    end
  endfunction

  // Offset removal and matrix products
  always_comb begin
    y_s = ($signed({12'b0, luma}) - 20'sd16) * 20'sd298;
    u_s = $signed({12'b0, chroma_blue}) - 20'sd128;
    v_s = $signed({12'b0, chroma_red}) - 20'sd128;
    r_t = y_s + 20'sd409 * v_s + 20'sd128;
    g_t = y_s - 20'sd100 * u_s - 20'sd208 * v_s + 20'sd128;
    b_t = y_s + 20'sd516 * u_s + 20'sd128;
    r8  = scale_sat(r_t);
    g8  = scale_sat(g_t);
    b8  = scale_sat(b_t);
  end

  // Pack by layout; unused codes fall back to BGRA
  always_comb begin
    unique case (output_format)
      yuvp_pkg::FMT_ABGR: begin
        pixel_word = {8'd0, b8, g8, r8};
        byte_count = yuvp_pkg::BYTES_WORD;
      end
      yuvp_pkg::FMT_BGR: begin
        pixel_word = {8'd0, r8, g8, b8};
        byte_count = yuvp_pkg::BYTES_PACKED;
      end
      yuvp_pkg::FMT_RGBA: begin
        pixel_word = {r8, g8, b8, 8'd0};
        byte_count = yuvp_pkg::BYTES_WORD;
      end
      yuvp_pkg::FMT_RGB: begin
        pixel_word = {8'd0, b8, g8, r8};
        byte_count = yuvp_pkg::BYTES_PACKED;
      end
      default: begin
        pixel_word = {b8, g8, r8, 8'd0};
        byte_count = yuvp_pkg::BYTES_WORD;
      end
    endcase
  end

endmodule

// File: hdl/yuv_to_rgb_pixel_packer.sv
// ----------------------------------------------------------------------------
// yuv_to_rgb_pixel_packer
// Streams YUV pixels in raster order, converts them to RGB and packs them.
//
//   channel | direction | tdata (low bit up)                   | side band
//   in_     | sink      | luma, chroma_blue, chroma_red (24b)  | -
//   out_    | source    | pixel_word, byte_count, pad (40b)    | tlast=row_end,
//           |           |                                      | tuser=frame_end
//   cfg_    | sink      | write index 0..2, data 13b           | no read-back
//
// One pixel per clock sustained while out_tready stays high; each pixel passes
// the input register, then conversion into the result reg, from request to output.
// The counters are sampled at input acceptance, so flags follow input order.
// Once both registers hold a pixel, in_tready follows out_tready in the same
// cycle; each register refills as it drains.
// Synchronous active-low reset clears valids and counters and sets config to BGRA, 1x1.
// ----------------------------------------------------------------------------
module yuv_to_rgb_pixel_packer #(
  parameter int MAX_DIMENSION = yuvp_pkg::MAX_DIMENSION_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // luma [7:0], chroma_blue [15:8], chroma_red [23:16]
  input  logic [23:0]                     in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // pixel_word [31:0], byte_count [34:32], zero [39:35]
  output logic [39:0]                     out_tdata,
  output logic                            out_tlast,
  // frame_end [0]
  output logic                            out_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [yuvp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [yuvp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW = yuvp_pkg::SAMPLE_W;

  yuvp_pkg::fmt_t                fmt_r;
  logic [yuvp_pkg::CFG_DIM_W-1:0] width_r, height_r;

  logic                 s1_vld_r;
  logic [SW-1:0]        s1_luma_r, s1_cb_r, s1_cr_r;
  yuvp_pkg::pos_flags_t s1_flags_r;
  logic                 s1_ready, out_ready;

  logic                            out_vld_r;
  logic [yuvp_pkg::WORD_W-1:0]     out_word_r;
  logic [yuvp_pkg::BYTES_W-1:0]    out_bytes_r;
  yuvp_pkg::pos_flags_t            out_flags_r;

  logic                            in_req;
  yuvp_pkg::pos_flags_t            pos_flags;
  logic [yuvp_pkg::WORD_W-1:0]     cv_word;
  logic [yuvp_pkg::BYTES_W-1:0]    cv_bytes;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= yuvp_pkg::FMT_BGRA;
      width_r  <= yuvp_pkg::CFG_DIM_W'(1);
      height_r <= yuvp_pkg::CFG_DIM_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        yuvp_pkg::REG_OUTPUT_FORMAT:
          fmt_r <= yuvp_pkg::fmt_t'(cfg_wdata[yuvp_pkg::CFG_FMT_W-1:0]);
        yuvp_pkg::REG_FRAME_WIDTH:   width_r  <= cfg_wdata[yuvp_pkg::CFG_DIM_W-1:0];
        yuvp_pkg::REG_FRAME_HEIGHT:  height_r <= cfg_wdata[yuvp_pkg::CFG_DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage readiness: a stage takes a request when empty or draining
  assign out_ready = !out_vld_r || out_tready;
  assign s1_ready  = !s1_vld_r || out_ready;
  assign in_tready = s1_ready;
  assign in_req    = in_tvalid && in_tready;

  yuvp_raster #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_raster (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (in_req),
    .frame_width  (width_r),
    .frame_height (height_r),
    .flags        (pos_flags)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_ready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req) begin
      s1_luma_r  <= in_tdata[SW-1:0];
      s1_cb_r    <= in_tdata[2*SW-1:SW];
      s1_cr_r    <= in_tdata[3*SW-1:2*SW];
      s1_flags_r <= pos_flags;
    end
  end

  yuvp_convert u_convert (
    .luma          (s1_luma_r),
    .chroma_blue   (s1_cb_r),
    .chroma_red    (s1_cr_r),
    .output_format (fmt_r),
    .pixel_word    (cv_word),
    .byte_count    (cv_bytes)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ready) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_vld_r) begin
      out_word_r  <= cv_word;
      out_bytes_r <= cv_bytes;
      out_flags_r <= s1_flags_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, out_bytes_r, out_word_r};
  assign out_tlast  = out_flags_r.row_end;
  assign out_tuser  = out_flags_r.frame_end;

  // A frame end is always also a row end
  a_frame_is_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (!out_flags_r.frame_end || out_flags_r.row_end))
    else $error("frame end without row end");

  // A held input-stage pixel is not overwritten while the output stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !out_ready |=> s1_vld_r && $stable(s1_luma_r) && $stable(s1_flags_r))
    else $error("input stage lost a pixel under stall");

endmodule
